// File: hw/rtl/adaptive_lpc_sample_restore_unit_assert.svh
// Assertion macros for the adaptive LPC sample restore unit.
// Used by modules that check their own control logic; needs i_clk and i_rst_n in scope.
`ifndef ADAPTIVE_LPC_SAMPLE_RESTORE_UNIT_ASSERT_SVH
`define ADAPTIVE_LPC_SAMPLE_RESTORE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ALSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ALSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/alsr_pkg.sv
// Package for the adaptive LPC sample restore unit: types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps

package alsr_pkg;

    localparam logic [4:0] RUNNING_SUM_ORDER = 5'd31;
    localparam int unsigned ACC_W = 54;
    localparam logic [5:0] POS_MAX = 6'd63;

    localparam logic [1:0] CFG_ORDER  = 2'd0;
    localparam logic [1:0] CFG_QSHIFT = 2'd1;
    localparam logic [1:0] CFG_BITS   = 2'd2;

    localparam logic [4:0] ORDER_RST  = 5'd0;
    localparam logic [3:0] QSHIFT_RST = 4'd9;
    localparam logic [5:0] BITS_RST   = 6'd16;

    localparam logic MODE_TAP    = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_SUM,
        KIND_PRED
    } t_kind;

    typedef struct packed {
        logic       in_ready;
        logic       rd;
        logic       mac;
        logic       base_lat;
        logic       sum;
        logic       round;
        logic       fin;
        logic       ad_dif;
        logic       ad_term;
        logic       ad_upd;
        logic       push;
        logic [4:0] idx;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic       in_mode;
        t_kind      kind;
        logic [4:0] ord;
        logic       mac_busy;
        logic       rem_zero;
        logic       stop;
        logic       out_free;
    } t_status;

    function automatic logic [31:0] sext_to_width(input logic [31:0] u, input logic [5:0] bits);
        logic [5:0]  b;
        logic [31:0] mask;
        logic [31:0] res;
        b = (bits == 6'd0) ? 6'd1 : bits;
        if (b >= 6'd32) begin
            res = u;
        end else begin
            mask = (32'd1 << b[4:0]) - 32'd1;
            res  = u & mask;
            if (res[b[4:0] - 5'd1]) begin
                res = res | ~mask;
            end
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/alsr_ifs.sv
// Handshake channel interfaces: residual/tap input, restored sample output, register write.
// No dependencies.
`timescale 1ns / 1ps

interface alsr_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [4:0]  tap_index;
    logic signed [31:0] value;
    logic        first_in_block;
    logic        last_in_block;
    modport source (output valid, mode, tap_index, value, first_in_block, last_in_block,
                    input ready);
    modport sink (input valid, mode, tap_index, value, first_in_block, last_in_block,
                  output ready);
endinterface

interface alsr_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] restored_sample;
    logic        block_end;
    modport source (output valid, restored_sample, block_end, input ready);
    modport sink (input valid, restored_sample, block_end, output ready);
endinterface

interface alsr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [5:0]  wr_data;
    modport source (output valid, reg_index, wr_data, input ready);
    modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// File: hw/rtl/alsr_datapath.sv
// Datapath: config registers, sample history and tap memories, MAC pipeline, adaptation.
// Depends on alsr_pkg and the channel interfaces in alsr_ifs.sv.
`timescale 1ns / 1ps

module alsr_datapath import alsr_pkg::*; #(
    parameter int unsigned MAX_TAPS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    alsr_in_if.sink          i_in,
    alsr_out_if.source       o_out,
    alsr_cfg_if.sink         i_cfg,
    input  t_cmd             i_cmd,
    output t_status          o_status
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam logic [4:0] ORD_MAX = 5'(MAX_TAPS - 1);
    localparam logic [AW:0] DEPTH = MAX_TAPS[AW:0];

    logic [4:0]  r_order;
    logic [3:0]  r_qs;
    logic [5:0]  r_bits;
    logic [5:0]  r_pos;

    logic [31:0] r_smem [MAX_TAPS];
    logic [MAX_TAPS-1:0] r_svalid;
    logic [15:0] r_tmem [MAX_TAPS];
    logic [AW-1:0] r_wp;
    logic [31:0] r_sdat;
    logic        r_sdat_v;
    logic [15:0] r_tdat;

    logic [31:0] r_res;
    logic        r_last;
    logic [4:0]  r_ord;
    logic [31:0] r_base;
    logic        r_v1, r_v2, r_v3;
    logic signed [31:0] r_d2;
    logic signed [15:0] r_t2;
    logic signed [47:0] r_p3;
    logic signed [ACC_W-1:0] r_acc;
    logic [31:0] r_pq;
    logic [31:0] r_sample;
    logic [31:0] r_rem;
    logic        r_positive;
    logic [31:0] r_mag;
    logic [4:0]  r_wt;
    logic [32:0] r_term;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_out_last;

    logic        in_acc;
    logic        tap_load;
    logic        smp_acc;
    logic [4:0]  ord_eff;
    t_kind       kind;
    logic [AW:0] addr_sum;
    logic [AW:0] addr_wrap;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] tap_addr;
    logic [31:0] s_rd;
    logic [31:0] ad_diff;
    logic [15:0] tap_delta;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] shifted;
    logic [32:0] up_sum;
    logic [37:0] ad_prod;
    logic [31:0] n_rem;
    logic [5:0]  n_pos;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_cmd.in_ready;
    assign in_acc      = i_in.valid & i_in.ready;
    assign tap_load    = in_acc & (i_in.mode == MODE_TAP)
                         & ({1'b0, i_in.tap_index} < 6'(MAX_TAPS));
    assign smp_acc     = in_acc & (i_in.mode == MODE_SAMPLE);

    assign ord_eff = (r_order != RUNNING_SUM_ORDER && r_order > ORD_MAX) ? ORD_MAX : r_order;

    always_comb begin
        if (i_in.first_in_block || r_pos == 6'd0 || ord_eff == 5'd0) begin
            kind = KIND_PASS;
        end else if (ord_eff == RUNNING_SUM_ORDER || r_pos <= {1'b0, ord_eff}) begin
            kind = KIND_SUM;
        end else begin
            kind = KIND_PRED;
        end
    end

    always_comb begin
        if (i_in.first_in_block || r_pos == 6'd0) begin
            n_pos = 6'd1;
        end else if (r_pos < POS_MAX) begin
            n_pos = r_pos + 6'd1;
        end else begin
            n_pos = r_pos;
        end
        if (i_in.last_in_block) begin
            n_pos = 6'd0;
        end
    end

    // newest entry sits just below the write pointer
    assign tap_addr  = i_cmd.idx[AW-1:0];
    assign addr_sum  = {1'b0, r_wp} + DEPTH - (AW+1)'(1) - {1'b0, tap_addr};
    assign addr_wrap = (addr_sum >= DEPTH) ? addr_sum - DEPTH : addr_sum;
    assign rd_addr   = addr_wrap[AW-1:0];
    assign s_rd      = r_sdat_v ? r_sdat : 32'd0;

    assign ad_diff   = r_base - s_rd;
    always_comb begin
        if (ad_diff == 32'd0) begin
            tap_delta = 16'd0;
        end else if (ad_diff[31] ^ r_positive) begin
            tap_delta = 16'hFFFF;
        end else begin
            tap_delta = 16'd1;
        end
    end

    assign rnd     = (r_qs == 4'd0) ? '0 : (ACC_W'(1) <<< (r_qs - 4'd1));
    assign shifted = (r_acc + rnd) >>> r_qs;
    assign up_sum  = {1'b0, r_mag} + (33'd1 << r_qs) - 33'd1;
    assign ad_prod = r_term * {33'd0, r_wt};
    assign n_rem   = r_positive ? r_rem - ad_prod[31:0] : r_rem + ad_prod[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order     <= ORDER_RST;
            r_qs        <= QSHIFT_RST;
            r_bits      <= BITS_RST;
            r_pos       <= 6'd0;
            r_svalid    <= '0;
            r_wp        <= '0;
            r_sdat_v    <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.reg_index)
                    CFG_ORDER:  r_order <= i_cfg.wr_data[4:0];
                    CFG_QSHIFT: r_qs    <= i_cfg.wr_data[3:0];
                    CFG_BITS:   r_bits  <= i_cfg.wr_data;
                    default:    ;
                endcase
            end
            if (smp_acc) begin
                r_pos <= n_pos;
            end
            if (i_cmd.rd) begin
                r_sdat_v <= r_svalid[rd_addr];
            end
            r_v1 <= i_cmd.mac;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.push) begin
                r_svalid[r_wp] <= 1'b1;
                r_wp <= ({1'b0, r_wp} == DEPTH - (AW+1)'(1)) ? '0 : r_wp + AW'(1);
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_smem[r_wp] <= r_sample;
        end
        if (i_cmd.rd) begin
            r_sdat <= r_smem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tap_load) begin
            r_tmem[i_in.tap_index[AW-1:0]] <= i_in.value[15:0];
        end else if (i_cmd.ad_dif) begin
            r_tmem[tap_addr] <= r_tdat + tap_delta;
        end
        if (i_cmd.rd) begin
            r_tdat <= r_tmem[tap_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_res    <= i_in.value;
            r_last   <= i_in.last_in_block;
            r_ord    <= ord_eff;
            r_acc    <= '0;
            r_sample <= i_in.value;
        end
        if (i_cmd.base_lat) begin
            r_base <= s_rd;
        end
        r_d2 <= s_rd - r_base;
        r_t2 <= r_tdat;
        r_p3 <= r_d2 * r_t2;
        if (r_v3) begin
            r_acc <= r_acc + ACC_W'(r_p3);
        end
        if (i_cmd.sum) begin
            r_sample <= sext_to_width(s_rd + r_res, r_bits);
        end
        if (i_cmd.round) begin
            r_pq <= shifted[31:0];
        end
        if (i_cmd.fin) begin
            r_sample   <= sext_to_width(r_pq + r_base + r_res, r_bits);
            r_rem      <= r_res;
            r_positive <= ~r_res[31];
        end
        if (i_cmd.ad_dif) begin
            r_mag <= ad_diff[31] ? (~ad_diff + 32'd1) : ad_diff;
            r_wt  <= r_ord - i_cmd.idx;
        end
        if (i_cmd.ad_term) begin
            r_term <= r_positive ? {1'b0, r_mag >> r_qs} : (up_sum >> r_qs);
        end
        if (i_cmd.ad_upd) begin
            r_rem <= n_rem;
        end
        if (i_cmd.push) begin
            r_out_data <= r_sample;
            r_out_last <= r_last;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.restored_sample = r_out_data;
    assign o_out.block_end       = r_out_last;

    assign o_status.in_valid = i_in.valid;
    assign o_status.in_mode  = i_in.mode;
    assign o_status.kind     = kind;
    assign o_status.ord      = r_ord;
    assign o_status.mac_busy = r_v1 | r_v2 | r_v3;
    assign o_status.rem_zero = (r_res == 32'd0);
    assign o_status.stop     = r_positive ? (n_rem[31] || n_rem == 32'd0) : ~n_rem[31];
    assign o_status.out_free = ~r_out_valid | o_out.ready;

endmodule

// File: hw/rtl/alsr_controller.sv
// Controller: sequences accept, prediction MAC, adaptation and result push.
// Depends on alsr_pkg and adaptive_lpc_sample_restore_unit_assert.svh.
`timescale 1ns / 1ps
`include "adaptive_lpc_sample_restore_unit_assert.svh"

module alsr_controller import alsr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_SUMW,
        S_RDBASE,
        S_BASEW,
        S_MAC,
        S_DRAIN,
        S_ROUND,
        S_FINAL,
        S_AD_RD,
        S_AD_DIF,
        S_AD_TERM,
        S_AD_UPD,
        S_DONE
    } t_state;

    t_state     r_state;
    logic [4:0] r_idx;

    always_comb begin
        o_cmd          = '0;
        o_cmd.idx      = r_idx;
        unique case (r_state)
            S_IDLE:    o_cmd.in_ready = 1'b1;
            S_RD0:     o_cmd.rd = 1'b1;
            S_SUMW:    o_cmd.sum = 1'b1;
            S_RDBASE: begin
                o_cmd.rd  = 1'b1;
                o_cmd.idx = i_status.ord;
            end
            S_BASEW:   o_cmd.base_lat = 1'b1;
            S_MAC: begin
                o_cmd.rd  = 1'b1;
                o_cmd.mac = 1'b1;
            end
            S_DRAIN:   ;
            S_ROUND:   o_cmd.round = 1'b1;
            S_FINAL:   o_cmd.fin = 1'b1;
            S_AD_RD:   o_cmd.rd = 1'b1;
            S_AD_DIF:  o_cmd.ad_dif = 1'b1;
            S_AD_TERM: o_cmd.ad_term = 1'b1;
            S_AD_UPD:  o_cmd.ad_upd = 1'b1;
            S_DONE:    o_cmd.push = i_status.out_free;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 5'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= 5'd0;
                    if (i_status.in_valid && i_status.in_mode == MODE_SAMPLE) begin
                        unique case (i_status.kind)
                            KIND_PASS: r_state <= S_DONE;
                            KIND_SUM:  r_state <= S_RD0;
                            KIND_PRED: r_state <= S_RDBASE;
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end
                S_RD0:    r_state <= S_SUMW;
                S_SUMW:   r_state <= S_DONE;
                S_RDBASE: r_state <= S_BASEW;
                S_BASEW: begin
                    r_idx   <= 5'd0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_idx <= r_idx + 5'd1;
                    if (r_idx == i_status.ord - 5'd1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!i_status.mac_busy) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND:  r_state <= S_FINAL;
                S_FINAL: begin
                    r_idx   <= i_status.ord - 5'd1;
                    r_state <= i_status.rem_zero ? S_DONE : S_AD_RD;
                end
                S_AD_RD:   r_state <= S_AD_DIF;
                S_AD_DIF:  r_state <= S_AD_TERM;
                S_AD_TERM: r_state <= S_AD_UPD;
                S_AD_UPD: begin
                    if (i_status.stop || r_idx == 5'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx - 5'd1;
                        r_state <= S_AD_RD;
                    end
                end
                S_DONE: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ALSR_ASSERT_NOW(a_push_free, o_cmd.push, i_status.out_free, "push into a full output register")
    `ALSR_ASSERT_NOW(a_mac_idx, r_state == S_MAC, r_idx < i_status.ord, "tap index beyond order")
    `ALSR_ASSERT_NEXT(a_push_idle, o_cmd.push, r_state == S_IDLE, "no return to idle after push")
    `ALSR_ASSERT_NOW(a_adapt_idx, r_state == S_AD_UPD, r_idx < i_status.ord, "adapt index beyond order")

endmodule

// File: hw/rtl/adaptive_lpc_sample_restore_unit.sv
// Adaptive LPC sample restorer: one item per transaction, a tap load or a residual. A tap load
// is written straight into the tap memory. A residual is passed through, added to the newest
// history sample as a running sum, or, for a predicted sample of order N, run through the single
// 32x16 multiply-accumulate pipeline and then adapted tap by tap (up to N taps), paced by the one
// read port of the sample history memory. A finished sample waits in the output register while
// the next transaction is accepted. History is cleared by valid bits; no clearing pass.
// Depends on alsr_pkg, alsr_ifs.sv, alsr_controller and alsr_datapath.
`timescale 1ns / 1ps

module adaptive_lpc_sample_restore_unit import alsr_pkg::*; #(
    parameter int unsigned MAX_TAPS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alsr_in_if.sink     i_in,
    alsr_out_if.source  o_out,
    alsr_cfg_if.sink    i_cfg
);

    t_cmd    cmd;
    t_status status;

    alsr_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    alsr_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for adaptive_lpc_sample_restore_unit: a directed table, then random
// residual blocks under many register settings, each restored sample checked against an
// in-bench adaptive predictor. Depends on alsr_pkg, alsr_ifs.sv and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;
    import alsr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_HOLD = 600;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 150;

    typedef struct {
        logic        mode;
        logic [4:0]  tap;
        logic [31:0] value;
        logic        first;
        logic        last;
    } item_t;

    typedef struct {
        bit          is_reg;
        logic [1:0]  ridx;
        logic [5:0]  rdata;
        item_t       it;
        bit          typed;
        logic [31:0] typed_sample;
    } row_t;

    typedef struct {
        logic [31:0] sample;
        logic        blk_end;
    } sample_t;

    logic i_clk;
    logic i_rst_n;

    alsr_in_if  in_ch();
    alsr_out_if out_ch();
    alsr_cfg_if cfg_ch();

    adaptive_lpc_sample_restore_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor state
    logic [31:0] hist [32];
    logic [15:0] taps [32];
    int unsigned blk_pos;
    int unsigned cur_order;
    int unsigned cur_shift;
    int unsigned cur_bits;

    sample_t pending_q[$];
    row_t    rows[$];
    int      errors;
    int      samples_checked;
    int      items_sent;
    int      reg_writes;
    int      quiet_cycles;
    bit      hold_req;
    int      burst_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] widen(logic [31:0] u);
        int unsigned b;
        logic [31:0] m;
        b = (cur_bits == 0) ? 1 : cur_bits;
        if (b >= 32) return u;
        m = (32'd1 << b) - 32'd1;
        u = u & m;
        if (u[b-1]) u = u | ~m;
        return u;
    endfunction

    function automatic logic [31:0] predict_adapt(int ord, logic [31:0] res);
        logic [31:0] base, d32, r, outv;
        longint acc, rem, diff, mag, up;
        int dir, k;
        bit pos;
        base = hist[ord];
        acc = 0;
        for (int c = 0; c < ord; c++) begin
            d32 = hist[c] - base;
            acc += longint'(signed'(d32)) * longint'(signed'(taps[c]));
        end
        if (cur_shift > 0) acc += longint'(1) << (cur_shift - 1);
        acc = acc >>> cur_shift;
        outv = widen(acc[31:0] + base + res);
        rem = longint'(signed'(res));
        if (rem != 0) begin
            pos = rem > 0;
            for (k = ord - 1; k >= 0; k--) begin
                d32 = base - hist[k];
                diff = longint'(signed'(d32));
                dir = (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
                mag = (diff < 0) ? -diff : diff;
                r = rem[31:0];
                if (pos) begin
                    taps[k] = taps[k] - 16'(dir);
                    r = r - 32'((mag >>> cur_shift) * longint'(ord - k));
                    rem = longint'(signed'(r));
                    if (rem <= 0) break;
                end else begin
                    up = (mag + (longint'(1) << cur_shift) - 1) >>> cur_shift;
                    taps[k] = taps[k] + 16'(dir);
                    r = r + 32'(up * longint'(ord - k));
                    rem = longint'(signed'(r));
                    if (rem >= 0) break;
                end
            end
        end
        return outv;
    endfunction

    // returns 1 when the item yields a restored sample
    function automatic bit restore_sample(item_t it, output sample_t res);
        int ord;
        logic [31:0] s;
        res.sample = '0;
        res.blk_end = 1'b0;
        if (it.mode == MODE_TAP) begin
            taps[it.tap] = it.value[15:0];
            return 1'b0;
        end
        ord = cur_order;
        if (it.first || blk_pos == 0) begin
            s = it.value;
            blk_pos = 1;
        end else begin
            if (ord == 0) s = it.value;
            else if (ord == RUNNING_SUM_ORDER || blk_pos <= ord) s = widen(hist[0] + it.value);
            else s = predict_adapt(ord, it.value);
            if (blk_pos < 63) blk_pos++;
        end
        for (int i = 31; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = s;
        res.sample = s;
        res.blk_end = it.last;
        if (it.last) blk_pos = 0;
        return 1'b1;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    function automatic void add_item(logic mode, logic [4:0] tap, logic [31:0] v, logic f,
                                     logic l, bit typed = 0, logic [31:0] want = '0);
        row_t r;
        r.is_reg = 0;
        r.ridx = '0;
        r.rdata = '0;
        r.it = '{mode, tap, v, f, l};
        r.typed = typed;
        r.typed_sample = want;
        rows.push_back(r);
    endfunction

    function automatic void add_reg(logic [1:0] idx, logic [5:0] data);
        row_t r;
        r = '{default: '0};
        r.is_reg = 1;
        r.ridx = idx;
        r.rdata = data;
        rows.push_back(r);
    endfunction

    task automatic send_item(item_t it, bit typed, logic [31:0] want);
        sample_t res;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= it.mode;
        in_ch.tap_index <= it.tap;
        in_ch.value <= it.value;
        in_ch.first_in_block <= it.first;
        in_ch.last_in_block <= it.last;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        items_sent++;
        if (restore_sample(it, res)) begin
            if (typed) res.sample = want;
            pending_q.push_back(res);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [5:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
        case (idx)
            CFG_ORDER:  cur_order = data & 6'd31;
            CFG_QSHIFT: cur_shift = data & 6'd15;
            CFG_BITS:   cur_bits = data;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_residual();
        case ($urandom_range(0, 15))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'd0;
            default: return 32'($urandom_range(0, 800)) - 32'd400;
        endcase
    endfunction

    // receiver
    initial begin
        int phase_len;
        bit always_ready;
        out_ch.ready = 1'b0;
        phase_len = 0;
        always_ready = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 0;
            end else begin
                if (phase_len == 0) begin
                    phase_len = $urandom_range(20, 300);
                    always_ready = $urandom_range(0, 2) == 0;
                end
                phase_len--;
                out_ch.ready <= always_ready || ($urandom_range(0, 9) < 6);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        sample_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected sample", out_ch.restored_sample, '0);
            end else begin
                want = pending_q.pop_front();
                samples_checked++;
                if (out_ch.restored_sample !== want.sample)
                    report("restored_sample", out_ch.restored_sample, want.sample);
                if (out_ch.block_end !== want.blk_end)
                    report("block_end", 32'(out_ch.block_end), 32'(want.blk_end));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d samples outstanding", pending_q.size());
            $display("adaptive_lpc_sample_restore_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        item_t it;
        int n, blk_len;
        logic [5:0] ord_pick, shift_pick, bits_pick;
        bit open_blk;
        errors = 0;
        samples_checked = 0;
        items_sent = 0;
        reg_writes = 0;
        quiet_cycles = 0;
        hold_req = 0;
        burst_left = 0;
        foreach (hist[i]) hist[i] = '0;
        foreach (taps[i]) taps[i] = '0;
        blk_pos = 0;
        cur_order = ORDER_RST;
        cur_shift = QSHIFT_RST;
        cur_bits = BITS_RST;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_TAP;
        in_ch.tap_index = '0;
        in_ch.value = '0;
        in_ch.first_in_block = 1'b0;
        in_ch.last_in_block = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.wr_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_item(MODE_SAMPLE, 0, 32'h7fff_ffff, 1, 0, 1, 32'h7fff_ffff);
        add_item(MODE_SAMPLE, 0, 32'h8000_0000, 0, 1, 1, 32'h8000_0000);
        add_item(MODE_SAMPLE, 0, 32'd5, 0, 0, 1, 32'd5);
        add_item(MODE_SAMPLE, 0, 32'hffff_ffff, 0, 1, 1, 32'hffff_ffff);
        add_item(MODE_TAP, 0, 32'h0001_7fff, 0, 0);
        add_item(MODE_TAP, 1, 32'hffff_8000, 0, 0);
        add_item(MODE_TAP, 2, 32'h0000_0100, 0, 0);
        add_item(MODE_TAP, 3, 32'hffff_fe00, 0, 0);
        add_item(MODE_TAP, 31, 32'h0000_0000, 1, 1);
        add_reg(CFG_ORDER, 6'd31);
        add_reg(CFG_BITS, 6'd8);
        add_item(MODE_SAMPLE, 0, 32'd100, 1, 0, 1, 32'd100);
        add_item(MODE_SAMPLE, 0, 32'd200, 0, 1, 1, 32'd44);
        add_reg(CFG_ORDER, 6'd2);
        add_reg(CFG_QSHIFT, 6'd0);
        add_reg(CFG_BITS, 6'd32);
        add_item(MODE_SAMPLE, 0, 32'd10, 1, 0);
        add_item(MODE_SAMPLE, 0, 32'd20, 0, 0);
        add_item(MODE_SAMPLE, 0, 32'd30, 0, 0);
        add_item(MODE_SAMPLE, 0, 32'd40, 0, 0);
        add_item(MODE_SAMPLE, 0, -32'sd60, 0, 1);
        add_reg(CFG_ORDER, 6'd4);
        add_reg(CFG_QSHIFT, 6'd15);
        add_reg(CFG_BITS, 6'd1);
        for (int i = 0; i < 6; i++) add_item(MODE_SAMPLE, 0, 32'(i * 3 - 7), i == 0, i == 5);

        foreach (rows[i]) begin
            if (rows[i].is_reg) begin
                drain();
                write_reg(rows[i].ridx, rows[i].rdata);
            end else begin
                send_item(rows[i].it, rows[i].typed, rows[i].typed_sample);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin ord_pick = 31; shift_pick = 0;  bits_pick = 0;  end
                1: begin ord_pick = 30; shift_pick = 15; bits_pick = 63; end
                2: begin ord_pick = 1;  shift_pick = 9;  bits_pick = 32; end
                3: begin ord_pick = 8;  shift_pick = 4;  bits_pick = 16; end
                4: begin ord_pick = 0;  shift_pick = 3;  bits_pick = 24; end
                default: begin
                    ord_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(1, 8);
                    shift_pick = $urandom_range(0, 15);
                    bits_pick = $urandom_range(0, 63);
                end
            endcase
            write_reg(CFG_ORDER, ord_pick | 6'($urandom_range(0, 1) << 5));
            write_reg(CFG_QSHIFT, shift_pick | 6'($urandom_range(0, 3) << 4));
            write_reg(CFG_BITS, bits_pick);
            if (ph == 0) begin
                for (int t = 0; t < 32; t++) begin
                    it = '{MODE_TAP, 5'(t), $urandom(), 1'($urandom), 1'($urandom)};
                    if (t < 2) it.value[15:0] = (t == 0) ? 16'h7fff : 16'h8000;
                    else it.value[15:0] = 16'($urandom_range(0, 1024)) - 16'd512;
                    send_item(it, 0, '0);
                end
            end
            if (ph == 3) hold_req = 1;
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                blk_len = $urandom_range(1, 40);
                open_blk = $urandom_range(0, 9) != 0;
                for (int j = 0; j < blk_len; j++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        it = '{MODE_TAP, 5'($urandom), $urandom(), 1'($urandom), 1'($urandom)};
                        it.value[15:0] = 16'($urandom_range(0, 2048)) - 16'd1024;
                        send_item(it, 0, '0);
                    end
                    it.mode = MODE_SAMPLE;
                    it.tap = 5'($urandom);
                    it.value = rand_residual();
                    it.first = (j == 0) ? open_blk : ($urandom_range(0, 49) == 0);
                    it.last = (j == blk_len - 1) ? ($urandom_range(0, 9) != 0)
                                                 : ($urandom_range(0, 49) == 0);
                    send_item(it, 0, '0);
                    n++;
                end
            end
        end

        drain();
        $display("run covered %0d transactions, %0d restored samples checked, %0d register writes",
                 items_sent, samples_checked, reg_writes);
        $display("orders 0 to 31, shifts 0 to 15, widths 0 to 63, with long output stalls");
        if (errors == 0) begin
            $display("adaptive_lpc_sample_restore_unit verification clean");
        end else begin
            $display("adaptive_lpc_sample_restore_unit verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/alsr_pkg.sv
hw/rtl/alsr_ifs.sv
hw/rtl/alsr_datapath.sv
hw/rtl/alsr_controller.sv
hw/rtl/adaptive_lpc_sample_restore_unit.sv
tb/sv/tb_top.sv
